[rtl/psspr_pkg.sv]
// shared types, constants and helpers for the plane strain/stress polar rotate block
`default_nettype none
package psspr_pkg;

  localparam int QW        = 31;
  localparam int LAT_HOOKE = 7;
  localparam int LAT_ROT   = 4;
  localparam int LAT_CS    = 3 + QW;
  localparam int LAT_TOTAL = LAT_CS + LAT_ROT;
  localparam int SAT_W     = 96;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_POISSON = 3'd1;
  localparam logic [2:0] CFG_K_MAIN  = 3'd2;
  localparam logic [2:0] CFG_K_CROSS = 3'd3;
  localparam logic [2:0] CFG_K_SHEAR = 3'd4;
  localparam logic [2:0] CFG_K_ZZ    = 3'd5;
  localparam logic [2:0] CFG_CYL     = 3'd6;

  localparam logic MODE_PSTRAIN = 1'b0;
  localparam logic MODE_PSTRESS = 1'b1;

  localparam logic [15:0] POISSON_RST = 16'd19661;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef struct packed {
    logic               mode;
    logic [15:0]        poisson;
    logic signed [47:0] k_main;
    logic signed [47:0] k_cross;
    logic signed [47:0] k_shear;
    logic signed [30:0] k_zz;
    logic               cyl_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] exx;
    logic signed [31:0] eyy;
    logic signed [31:0] exy;
    logic signed [31:0] ezz;
    logic signed [31:0] szz;
  } hk_res_t;

  typedef struct packed {
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [32:0] t2;
  } tens_t;

  typedef struct packed {
    logic signed [31:0] rr;
    logic signed [31:0] tt;
    logic signed [31:0] rt;
  } rot_res_t;

  typedef struct packed {
    logic negc;
    logic negs;
    logic zero;
  } cs_flag_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 96'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -96'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] a);
    logic signed [31:0] r;
    if (a > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (a < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/psspr_div.sv]
// pipelined restoring divider, one quotient bit per stage, floor(num*2^30/den)
`default_nettype none
module psspr_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [63:0]             num,
  input  logic [63:0]             den,
  output logic [psspr_pkg::QW-1:0] quo
);

  logic [63:0]                rem_r [psspr_pkg::QW-1];
  logic [63:0]                den_r [psspr_pkg::QW-1];
  logic [psspr_pkg::QW-1:0]   q_r   [psspr_pkg::QW];

  genvar k;
  for (k = 0; k < psspr_pkg::QW; k++) begin : g_step
    logic [64:0]              t;
    logic [63:0]              d;
    logic [psspr_pkg::QW-1:0] qin;
    logic [64:0]              diff;
    logic                     ge;

    if (k == 0) begin : g_first
      assign t   = {1'b0, num};
      assign d   = den;
      assign qin = '0;
    end else begin : g_next
      assign t   = {rem_r[k-1], 1'b0};
      assign d   = den_r[k-1];
      assign qin = q_r[k-1];
    end

    assign ge   = t >= {1'b0, d};
    assign diff = t - {1'b0, d};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {qin[psspr_pkg::QW-2:0], ge};
      end
    end

    if (k < psspr_pkg::QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[63:0] : t[63:0];
          den_r[k] <= d;
        end
      end
    end
  end

  assign quo = q_r[psspr_pkg::QW-1];

endmodule
`default_nettype wire

[rtl/psspr_hooke.sv]
// hooke law pipeline: plane strains, out-of-plane strain or stress
`default_nettype none
module psspr_hooke (
  input  logic                     clk,
  input  logic                     en,
  input  psspr_pkg::cfg_t          cfg,
  input  logic signed [31:0]       sxx,
  input  logic signed [31:0]       syy,
  input  logic signed [31:0]       txy,
  output psspr_pkg::hk_res_t       res
);

  logic signed [15:0] kmh, kch, ksh;
  logic signed [32:0] kml, kcl, ksl;

  assign kmh = cfg.k_main[47:32];
  assign kch = cfg.k_cross[47:32];
  assign ksh = cfg.k_shear[47:32];
  assign kml = $signed({1'b0, cfg.k_main[31:0]});
  assign kcl = $signed({1'b0, cfg.k_cross[31:0]});
  assign ksl = $signed({1'b0, cfg.k_shear[31:0]});

  // stage 1: partial products
  logic signed [47:0] mxh_r, myh_r, cxh_r, cyh_r, sh_r;
  logic signed [64:0] mxl_r, myl_r, cxl_r, cyl_r, sl_r;
  logic signed [32:0] ssum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mxh_r  <= 48'(kmh) * 48'(sxx);
      myh_r  <= 48'(kmh) * 48'(syy);
      cxh_r  <= 48'(kch) * 48'(sxx);
      cyh_r  <= 48'(kch) * 48'(syy);
      sh_r   <= 48'(ksh) * 48'(txy);
      mxl_r  <= 65'(kml) * 65'(sxx);
      myl_r  <= 65'(kml) * 65'(syy);
      cxl_r  <= 65'(kcl) * 65'(sxx);
      cyl_r  <= 65'(kcl) * 65'(syy);
      sl_r   <= 65'(ksl) * 65'(txy);
      ssum_r <= 33'(sxx) + 33'(syy);
    end
  end

  // stage 2: full products
  logic signed [79:0] fmx_r, fmy_r, fcx_r, fcy_r, fs_r;
  logic signed [49:0] pz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fmx_r <= $signed({mxh_r, 32'd0}) + 80'(mxl_r);
      fmy_r <= $signed({myh_r, 32'd0}) + 80'(myl_r);
      fcx_r <= $signed({cxh_r, 32'd0}) + 80'(cxl_r);
      fcy_r <= $signed({cyh_r, 32'd0}) + 80'(cyl_r);
      fs_r  <= $signed({sh_r, 32'd0}) + 80'(sl_r);
      pz_r  <= 50'($signed({1'b0, cfg.poisson})) * 50'(ssum_r);
    end
  end

  // stage 3: differences, out-of-plane stress
  logic signed [80:0] dxx_r, dyy_r;
  logic signed [79:0] fs3_r;
  logic signed [31:0] szz3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dxx_r  <= 81'(fmx_r) - 81'(fcy_r);
      dyy_r  <= 81'(fmy_r) - 81'(fcx_r);
      fs3_r  <= fs_r;
      szz3_r <= psspr_pkg::sat32(96'(pz_r >>> 16));
    end
  end

  // stage 4: scale and saturate strains
  psspr_pkg::hk_res_t r4_r, r5_r, r6_r, r7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r4_r.exx <= psspr_pkg::sat32(96'(dxx_r >>> 34));
      r4_r.eyy <= psspr_pkg::sat32(96'(dyy_r >>> 34));
      r4_r.exy <= psspr_pkg::sat32(96'(fs3_r >>> 34));
      r4_r.ezz <= '0;
      r4_r.szz <= szz3_r;
    end
  end

  // stage 5..7: plane stress out-of-plane strain
  logic signed [32:0] esum_r;
  logic signed [63:0] pzz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      esum_r <= 33'(r4_r.exx) + 33'(r4_r.eyy);
      r5_r   <= r4_r;
      pzz_r  <= 64'(cfg.k_zz) * 64'(esum_r);
      r6_r   <= r5_r;
      r7_r.exx <= r6_r.exx;
      r7_r.eyy <= r6_r.eyy;
      r7_r.exy <= r6_r.exy;
      r7_r.ezz <= (cfg.mode == psspr_pkg::MODE_PSTRESS) ?
                  psspr_pkg::sat32(96'(pzz_r >>> 30)) : '0;
      r7_r.szz <= (cfg.mode == psspr_pkg::MODE_PSTRAIN) ? r6_r.szz : '0;
    end
  end

  assign res = r7_r;

endmodule
`default_nettype wire

[rtl/psspr_rot.sv]
// polar rotation of one symmetric tensor by cos2t and sin2t
`default_nettype none
module psspr_rot (
  input  logic                  clk,
  input  logic                  en,
  input  psspr_pkg::tens_t      tin,
  input  logic signed [31:0]    c,
  input  logic signed [31:0]    s,
  output psspr_pkg::rot_res_t   res
);

  logic signed [64:0] pdc_r, pts_r, pds_r, ptc_r;
  logic signed [32:0] sum1_r, sum2_r;
  logic signed [65:0] var_r, sh2_r, sh3_r;
  logic signed [66:0] a_r, b_r;
  psspr_pkg::rot_res_t res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pdc_r  <= 65'(tin.dif) * 65'(c);
      pts_r  <= 65'(tin.t2) * 65'(s);
      pds_r  <= 65'(tin.dif) * 65'(s);
      ptc_r  <= 65'(tin.t2) * 65'(c);
      sum1_r <= tin.sum;
      var_r  <= 66'(pdc_r) + 66'(pts_r);
      sh2_r  <= 66'(ptc_r) - 66'(pds_r);
      sum2_r <= sum1_r;
      a_r    <= $signed({34'(sum2_r), 30'd0}) + 67'(var_r);
      b_r    <= $signed({34'(sum2_r), 30'd0}) - 67'(var_r);
      sh3_r  <= sh2_r;
      res_r.rr <= psspr_pkg::sat32(96'(a_r >>> 31));
      res_r.tt <= psspr_pkg::sat32(96'(b_r >>> 31));
      res_r.rt <= psspr_pkg::sat32(96'(sh3_r >>> 31));
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[rtl/plane_strain_stress_polar_rotate_top.sv]
// throughput one request per cycle while the output is not stalled
// the cos2t/sin2t path sets the depth: 2 geometry stages, 31 divider stages, 1 sign stage
// then 4 rotation stages; strain path runs 7 stages alongside
// a stall at the output freezes the whole pipeline, no request is dropped or repeated
// synchronous active-low reset clears the valid bits and loads register defaults
`default_nettype none
module plane_strain_stress_polar_rotate_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_stress_xx,
  input  logic signed [31:0] in_stress_yy,
  input  logic signed [31:0] in_shear_xy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_strain_xx,
  output logic signed [31:0] out_strain_yy,
  output logic signed [31:0] out_strain_xy,
  output logic signed [31:0] out_strain_zz,
  output logic signed [31:0] out_stress_zz,
  output logic signed [31:0] out_stress_rr,
  output logic signed [31:0] out_stress_tt,
  output logic signed [31:0] out_shear_rt,
  output logic signed [31:0] out_strain_rr,
  output logic signed [31:0] out_strain_tt,
  output logic signed [31:0] out_strain_rt
);

  psspr_pkg::cfg_t cfg_r;
  logic [psspr_pkg::LAT_TOTAL-1:0] v_r;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = !v_r[psspr_pkg::LAT_TOTAL-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[psspr_pkg::LAT_TOTAL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= psspr_pkg::MODE_PSTRAIN;
      cfg_r.poisson    <= psspr_pkg::POISSON_RST;
      cfg_r.k_main     <= '0;
      cfg_r.k_cross    <= '0;
      cfg_r.k_shear    <= '0;
      cfg_r.k_zz       <= '0;
      cfg_r.cyl_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psspr_pkg::CFG_MODE:    cfg_r.mode       <= cfg_data[0];
        psspr_pkg::CFG_POISSON: cfg_r.poisson    <= cfg_data[15:0];
        psspr_pkg::CFG_K_MAIN:  cfg_r.k_main     <= cfg_data;
        psspr_pkg::CFG_K_CROSS: cfg_r.k_cross    <= cfg_data;
        psspr_pkg::CFG_K_SHEAR: cfg_r.k_shear    <= cfg_data;
        psspr_pkg::CFG_K_ZZ:    cfg_r.k_zz       <= cfg_data[30:0];
        psspr_pkg::CFG_CYL:     cfg_r.cyl_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[psspr_pkg::LAT_TOTAL-2:0], in_valid};
    end
  end

  // strain path
  psspr_pkg::hk_res_t hk;

  psspr_hooke u_hooke (
    .clk (clk),
    .en  (adv),
    .cfg (cfg_r),
    .sxx (in_stress_xx),
    .syy (in_stress_yy),
    .txy (in_shear_xy),
    .res (hk)
  );

  // geometry front end
  logic [31:0] ax, ay;
  logic [63:0] x2_r, y2_r, xy_r;
  logic        negs1_r, zero1_r;
  logic [63:0] r2_r, cn_r, sn_r;
  psspr_pkg::cs_flag_t fl2_r;
  psspr_pkg::cs_flag_t fl_r [psspr_pkg::QW];

  assign ax = in_pos_x[31] ? 32'(-in_pos_x) : in_pos_x;
  assign ay = in_pos_y[31] ? 32'(-in_pos_y) : in_pos_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r    <= 64'(ax) * 64'(ax);
      y2_r    <= 64'(ay) * 64'(ay);
      xy_r    <= 64'(ax) * 64'(ay);
      negs1_r <= in_pos_x[31] ^ in_pos_y[31];
      zero1_r <= (in_pos_x == '0) && (in_pos_y == '0);
      r2_r    <= x2_r + y2_r;
      cn_r    <= (x2_r >= y2_r) ? x2_r - y2_r : y2_r - x2_r;
      sn_r    <= {xy_r[62:0], 1'b0};
      fl2_r.negc <= x2_r < y2_r;
      fl2_r.negs <= negs1_r;
      fl2_r.zero <= zero1_r;
      fl_r[0] <= fl2_r;
      for (int i = 1; i < psspr_pkg::QW; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  logic [psspr_pkg::QW-1:0] qc, qs;

  psspr_div u_div_c (.clk(clk), .en(adv), .num(cn_r), .den(r2_r), .quo(qc));
  psspr_div u_div_s (.clk(clk), .en(adv), .num(sn_r), .den(r2_r), .quo(qs));

  logic signed [31:0] c_r, s_r;
  psspr_pkg::cs_flag_t flq;

  assign flq = fl_r[psspr_pkg::QW-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (flq.zero) begin
        c_r <= psspr_pkg::ONE_Q30;
        s_r <= '0;
      end else begin
        c_r <= flq.negc ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        s_r <= flq.negs ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
      end
    end
  end

  // tensor terms carried to the rotation
  psspr_pkg::tens_t ssh_r [psspr_pkg::LAT_CS];
  psspr_pkg::tens_t esh_r [psspr_pkg::LAT_CS-psspr_pkg::LAT_HOOKE];
  psspr_pkg::hk_res_t hr_r [psspr_pkg::LAT_TOTAL-psspr_pkg::LAT_HOOKE];

  always_ff @(posedge clk) begin
    if (adv) begin
      ssh_r[0].sum <= 33'(in_stress_xx) + 33'(in_stress_yy);
      ssh_r[0].dif <= 33'(in_stress_xx) - 33'(in_stress_yy);
      ssh_r[0].t2  <= {in_shear_xy, 1'b0};
      for (int i = 1; i < psspr_pkg::LAT_CS; i++) begin
        ssh_r[i] <= ssh_r[i-1];
      end
      esh_r[0].sum <= 33'(hk.exx) + 33'(hk.eyy);
      esh_r[0].dif <= 33'(hk.exx) - 33'(hk.eyy);
      esh_r[0].t2  <= {hk.exy, 1'b0};
      for (int i = 1; i < psspr_pkg::LAT_CS - psspr_pkg::LAT_HOOKE; i++) begin
        esh_r[i] <= esh_r[i-1];
      end
      hr_r[0] <= hk;
      for (int i = 1; i < psspr_pkg::LAT_TOTAL - psspr_pkg::LAT_HOOKE; i++) begin
        hr_r[i] <= hr_r[i-1];
      end
    end
  end

  psspr_pkg::rot_res_t rs, re;

  psspr_rot u_rot_stress (
    .clk (clk),
    .en  (adv),
    .tin (ssh_r[psspr_pkg::LAT_CS-1]),
    .c   (c_r),
    .s   (s_r),
    .res (rs)
  );

  psspr_rot u_rot_strain (
    .clk (clk),
    .en  (adv),
    .tin (esh_r[psspr_pkg::LAT_CS-psspr_pkg::LAT_HOOKE-1]),
    .c   (c_r),
    .s   (s_r),
    .res (re)
  );

  psspr_pkg::hk_res_t ho;

  assign ho            = hr_r[psspr_pkg::LAT_TOTAL-psspr_pkg::LAT_HOOKE-1];
  assign out_strain_xx = ho.exx;
  assign out_strain_yy = ho.eyy;
  assign out_strain_xy = ho.exy;
  assign out_strain_zz = ho.ezz;
  assign out_stress_zz = ho.szz;
  assign out_stress_rr = cfg_r.cyl_enable ? rs.rr : '0;
  assign out_stress_tt = cfg_r.cyl_enable ? rs.tt : '0;
  assign out_shear_rt  = cfg_r.cyl_enable ? rs.rt : '0;
  assign out_strain_rr = cfg_r.cyl_enable ? re.rr : '0;
  assign out_strain_tt = cfg_r.cyl_enable ? re.tt : '0;
  assign out_strain_rt = cfg_r.cyl_enable ? re.rt : '0;

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request did not enter the pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("valid chain moved during a stall");

  a_cs_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[psspr_pkg::LAT_CS-1] |->
      (c_r <= psspr_pkg::ONE_Q30) && (c_r >= -psspr_pkg::ONE_Q30) &&
      (s_r <= psspr_pkg::ONE_Q30) && (s_r >= -psspr_pkg::ONE_Q30))
    else $error("cos2t or sin2t out of range");

  a_zz_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_strain_zz == '0) || (out_stress_zz == '0))
    else $error("both out-of-plane terms nonzero");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench for the plane strain/stress block with polar rotation: random and directed nodes
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef logic [10:0][31:0] node_res_t;
  typedef struct packed {
    logic signed [31:0] x, y, sxx, syy, txy;
  } node_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_stress_xx = '0, in_stress_yy = '0;
  logic signed [31:0] in_shear_xy = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] o_exx, o_eyy, o_exy, o_ezz, o_szz, o_srr, o_stt, o_trt;
  logic signed [31:0] o_err, o_ett, o_ert;

  plane_strain_stress_polar_rotate_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_stress_xx(in_stress_xx), .in_stress_yy(in_stress_yy), .in_shear_xy(in_shear_xy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_strain_xx(o_exx), .out_strain_yy(o_eyy), .out_strain_xy(o_exy),
    .out_strain_zz(o_ezz), .out_stress_zz(o_szz), .out_stress_rr(o_srr),
    .out_stress_tt(o_stt), .out_shear_rt(o_trt), .out_strain_rr(o_err),
    .out_strain_tt(o_ett), .out_strain_rt(o_ert)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic               m_mode = psspr_pkg::MODE_PSTRAIN;
  logic [15:0]        m_poisson = psspr_pkg::POISSON_RST;
  logic signed [47:0] m_kmain = '0, m_kcross = '0, m_kshear = '0;
  logic signed [30:0] m_kzz = '0;
  logic               m_cyl = 1'b0;

  node_t pend_nodes[$];
  node_res_t exp_results[$];
  int errors = 0, n_nodes = 0, n_results = 0, n_cfg = 0;
  logic in_fire = 1'b0, out_fire = 1'b0, no_idle = 1'b0;
  int in_gap = 0, out_wait = 0;
  string fname[11] = '{"strain_xx", "strain_yy", "strain_xy", "strain_zz", "stress_zz",
                       "stress_rr", "stress_tt", "shear_rt", "strain_rr", "strain_tt",
                       "strain_rt"};

  function automatic logic signed [31:0] clamp32(wide_t a);
    if (a > 128'sd2147483647) return 32'sh7fffffff;
    if (a < -128'sd2147483648) return 32'sh80000000;
    return a[31:0];
  endfunction

  function automatic void polar(wide_t t11, wide_t t22, wide_t t12, wide_t c, wide_t s,
                                output logic signed [31:0] rr, tt, rt);
    wide_t base, var_t, sh;
    base = (t11 + t22) <<< 30;
    var_t = (t11 - t22) * c + 2 * t12 * s;
    sh = 2 * t12 * c - (t11 - t22) * s;
    rr = clamp32((base + var_t) >>> 31);
    tt = clamp32((base - var_t) >>> 31);
    rt = clamp32(sh >>> 31);
  endfunction

  function automatic node_res_t hooke_polar(node_t n);
    node_res_t r;
    wide_t x, y, sxx, syy, txy, km, kc, ks, kz, pr, exx, eyy, exy;
    wide_t ax, ay, x2, y2, r2, cn, c, s;
    logic signed [31:0] e0, e1, e2, a0, a1, a2;
    x = n.x; y = n.y; sxx = n.sxx; syy = n.syy; txy = n.txy;
    km = m_kmain; kc = m_kcross; ks = m_kshear; kz = m_kzz;
    pr = $signed({112'd0, m_poisson});
    r = '0;
    e0 = clamp32((km * sxx - kc * syy) >>> 34);
    e1 = clamp32((km * syy - kc * sxx) >>> 34);
    e2 = clamp32((ks * txy) >>> 34);
    exx = e0; eyy = e1; exy = e2;
    r[0] = e0; r[1] = e1; r[2] = e2;
    if (m_mode == psspr_pkg::MODE_PSTRESS) r[3] = clamp32((kz * (exx + eyy)) >>> 30);
    else r[4] = clamp32((pr * (sxx + syy)) >>> 16);
    if (m_cyl) begin
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      x2 = ax * ax; y2 = ay * ay; r2 = x2 + y2;
      if (r2 == 0) begin
        c = 128'sd1 <<< 30;
        s = 0;
      end else begin
        cn = x2 >= y2 ? x2 - y2 : y2 - x2;
        c = (cn <<< 30) / r2;
        if (x2 < y2) c = -c;
        s = ((2 * ax * ay) <<< 30) / r2;
        if ((x < 0) != (y < 0)) s = -s;
      end
      polar(sxx, syy, txy, c, s, a0, a1, a2);
      r[5] = a0; r[6] = a1; r[7] = a2;
      polar(exx, eyy, exy, c, s, a0, a1, a2);
      r[8] = a0; r[9] = a1; r[10] = a2;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // monitor: sample at rising edge
  always @(posedge clk) begin
    node_res_t got, want;
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (in_fire) begin
      exp_results.push_back(hooke_polar('{in_pos_x, in_pos_y, in_stress_xx, in_stress_yy,
                                          in_shear_xy}));
      n_nodes++;
    end
    if (out_fire) begin
      got = {o_exx, o_eyy, o_exy, o_ezz, o_szz, o_srr, o_stt, o_trt, o_err, o_ett, o_ert};
      got = {<<32{got}};
      n_results++;
      if (exp_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = exp_results.pop_front();
        for (int i = 0; i < 11; i++)
          if (got[i] !== want[i])
            report_mismatch($sformatf("%s got %0d exp %0d", fname[i],
                                      $signed(got[i]), $signed(want[i])));
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    node_t n;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pend_nodes.size() != 0) begin
      n = pend_nodes.pop_front();
      in_pos_x <= n.x; in_pos_y <= n.y;
      in_stress_xx <= n.sxx; in_stress_yy <= n.syy; in_shear_xy <= n.txy;
      in_valid <= 1'b1;
      in_gap <= no_idle ? 0 : $urandom_range(0, 5);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result stall
  always @(negedge clk) begin
    if (out_fire && !no_idle) begin
      out_wait <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else if (out_wait > 0 && !no_idle) begin
      out_wait <= out_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic wait_idle();
    while (pend_nodes.size() != 0 || in_valid || exp_results.size() != 0) @(posedge clk);
    repeat (psspr_pkg::LAT_TOTAL + 4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psspr_pkg::CFG_MODE:    m_mode = val[0];
      psspr_pkg::CFG_POISSON: m_poisson = val[15:0];
      psspr_pkg::CFG_K_MAIN:  m_kmain = val;
      psspr_pkg::CFG_K_CROSS: m_kcross = val;
      psspr_pkg::CFG_K_SHEAR: m_kshear = val;
      psspr_pkg::CFG_K_ZZ:    m_kzz = val[30:0];
      psspr_pkg::CFG_CYL:     m_cyl = val[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(logic md, logic [15:0] pr, logic [47:0] km, logic [47:0] kc,
                         logic [47:0] ks, logic [30:0] kz, logic cy);
    cfg_write(psspr_pkg::CFG_MODE, {47'd0, md});
    cfg_write(psspr_pkg::CFG_POISSON, {32'd0, pr});
    cfg_write(psspr_pkg::CFG_K_MAIN, km);
    cfg_write(psspr_pkg::CFG_K_CROSS, kc);
    cfg_write(psspr_pkg::CFG_K_SHEAR, ks);
    cfg_write(psspr_pkg::CFG_K_ZZ, {17'd0, kz});
    cfg_write(psspr_pkg::CFG_CYL, {47'd0, cy});
  endtask

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
      3: case ($urandom_range(0, 4))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 32'sd0;
           3: return -32'sd1;
           default: return 32'sd1;
         endcase
      default: return $signed($urandom_range(0, 65536 * 200)) - 32'sd6553600;
    endcase
  endfunction

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'sh7fffffffffff;
      2: return 48'sh800000000000;
      default: return $signed({1'b0, $urandom_range(0, 1 << 30)}) * ($urandom_range(0, 1) ?
                       48'sd1 : -48'sd1) <<< $urandom_range(0, 16);
    endcase
  endfunction

  task automatic push_random(int cnt);
    node_t n;
    repeat (cnt) begin
      n.x = pick32(); n.y = pick32(); n.sxx = pick32(); n.syy = pick32(); n.txy = pick32();
      if ($urandom_range(0, 15) == 0) begin
        n.x = 0; n.y = 0;
      end
      pend_nodes.push_back(n);
    end
  endtask

  task automatic push_directed();
    logic signed [31:0] v[6] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd65536,
                                 -32'sd65536};
    for (int i = 0; i < 6; i++)
      pend_nodes.push_back('{v[i], v[5 - i], v[i], v[(i + 1) % 6], v[(i + 2) % 6]});
    pend_nodes.push_back('{0, 0, 32'sd655360, -32'sd327680, 32'sd131072});
    pend_nodes.push_back('{32'sd65536, 0, 32'sd655360, 32'sd65536, 32'sd98304});
    pend_nodes.push_back('{0, -32'sd65536, 32'sd655360, 32'sd65536, 32'sd98304});
    pend_nodes.push_back('{32'sd65536, 32'sd65536, -32'sd655360, 32'sd65536, 32'sd98304});
    pend_nodes.push_back('{-32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536, -32'sd98304});
    pend_nodes.push_back('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                           32'sh80000000});
    pend_nodes.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh7fffffff});
    pend_nodes.push_back('{32'sd3, -32'sd7, 32'sd1, 32'sd0, -32'sd1});
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // reset values first
    push_directed();
    push_random(30);
    wait_idle();
    cfg_all(psspr_pkg::MODE_PSTRAIN, 16'd19661, 48'sd2147483648, 48'sd644245094,
            48'sd5583457485, 31'd0, 1'b1);
    push_directed();
    push_random(80);
    wait_idle();
    cfg_all(psspr_pkg::MODE_PSTRESS, 16'd0, 48'sh7fffffffffff, 48'sh800000000000,
            48'sh7fffffffffff, 31'h40000000, 1'b1);
    push_directed();
    push_random(70);
    wait_idle();
    cfg_all(psspr_pkg::MODE_PSTRAIN, 16'hffff, 48'sh800000000000, 48'sh7fffffffffff,
            48'sh800000000000, 31'h40000000, 1'b0);
    // index past the last register
    cfg_write(3'(psspr_pkg::CFG_CYL + 3'd1), 48'({$urandom, $urandom}));
    push_random(70);
    wait_idle();
    cfg_all(psspr_pkg::MODE_PSTRESS, 16'd32768, 48'sd4294967296, -48'sd1288490188,
            48'sd6000000000, 31'h6aaaaaab, 1'b1);
    no_idle = 1'b1;
    push_random(80);
    wait_idle();
    no_idle = 1'b0;
    for (int p = 0; p < 4; p++) begin
      cfg_all(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), pick48(), pick48(),
              pick48(),
              $urandom_range(0, 1) ?
                (31'h40000000 | 31'($urandom_range(0, (1 << 30) - 1))) : 31'd0,
              1'($urandom_range(0, 1)));
      push_random(70);
      wait_idle();
    end
    repeat (psspr_pkg::LAT_TOTAL + 10) @(posedge clk);
    $display("covered %0d node requests, %0d results, %0d register writes",
             n_nodes, n_results, n_cfg);
    $display("both modes, rotation on and off, compliance extremes, origin and axis nodes");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
